// ===== rtl/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon crossing unit.
// Holds the input and result payload structs and the queue entry format.
// No dependencies.
package pip_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int TALLY_BITS = 16;

	localparam logic [TALLY_BITS-1:0] TALLY_MAX = {TALLY_BITS{1'b1}};

	// Edge classes decided by the front end.
	localparam logic [1:0] KIND_SKIP = 2'd0;
	localparam logic [1:0] KIND_HIT  = 2'd1;
	localparam logic [1:0] KIND_TEST = 2'd2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] edge_ax;
		logic signed [COORD_BITS-1:0] edge_ay;
		logic signed [COORD_BITS-1:0] edge_bx;
		logic signed [COORD_BITS-1:0] edge_by;
		logic                         last_edge;
	} edge_in_t;

	typedef struct packed {
		logic                  inside_res;
		logic [TALLY_BITS-1:0] crossing_total;
	} result_t;

	typedef struct packed {
		logic [1:0]                  kind;
		logic                        dx_neg;
		logic                        last_edge;
		logic signed [DIFF_BITS-1:0] dpx;
		logic signed [DIFF_BITS-1:0] dy;
		logic signed [DIFF_BITS-1:0] dpy;
		logic signed [DIFF_BITS-1:0] dx;
	} job_t;

endpackage

// ===== rtl/pip_front.sv =====
// Front end of the crossing unit: classifies each incoming edge and forms
// the differences that the back end multiplies. Depends on pip_pkg.
module pip_front (
	input  pip_pkg::edge_in_t in_data,
	output pip_pkg::job_t     job
);

	logic signed [pip_pkg::DIFF_BITS-1:0] px, py, ax, ay, bx, by;
	logic signed [pip_pkg::DIFF_BITS-1:0] dx;
	logic                                 between;

	always_comb begin
		px = pip_pkg::DIFF_BITS'(in_data.point_x);
		py = pip_pkg::DIFF_BITS'(in_data.point_y);
		ax = pip_pkg::DIFF_BITS'(in_data.edge_ax);
		ay = pip_pkg::DIFF_BITS'(in_data.edge_ay);
		bx = pip_pkg::DIFF_BITS'(in_data.edge_bx);
		by = pip_pkg::DIFF_BITS'(in_data.edge_by);
		dx = ax - bx;
		between = ((ax < px) && (px < bx)) || ((ax > px) && (px > bx));

		job.dx_neg    = dx[pip_pkg::DIFF_BITS-1];
		job.last_edge = in_data.last_edge;
		job.dpx       = px - bx;
		job.dy        = ay - by;
		job.dpy       = py - by;
		job.dx        = dx;

		// A vertical edge is decided here; only a slanted edge that spans
		// the point's x needs the cross product test.
		if (dx == '0) begin
			job.kind = (px == ax) ? pip_pkg::KIND_HIT : pip_pkg::KIND_SKIP;
		end else if (between) begin
			job.kind = pip_pkg::KIND_TEST;
		end else begin
			job.kind = pip_pkg::KIND_SKIP;
		end
	end

endmodule

// ===== rtl/pip_fifo.sv =====
// Short queue of classified edges between the front and back ends.
// Register array with read and write pointers. Depends on pip_pkg.
module pip_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  pip_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output pip_pkg::job_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pip_pkg::job_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a lone write");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not follow a lone read");

endmodule

// ===== rtl/pip_back.sv =====
// Back end of the crossing unit: cross product stage, crossing tally and
// the result register. Depends on pip_pkg.
module pip_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_ready,
	input  pip_pkg::job_t    job,
	output logic             out_valid,
	input  logic             out_ready,
	output pip_pkg::result_t out_data
);

	// Stage 1: products registered.
	logic                                 valid_s1;
	logic [1:0]                           kind_s1;
	logic                                 dx_neg_s1;
	logic                                 last_s1;
	logic signed [pip_pkg::PROD_BITS-1:0] lhs_s1, rhs_s1;

	logic [pip_pkg::TALLY_BITS-1:0] tally_q;
	logic                           parity_q;
	logic                           out_valid_q;
	pip_pkg::result_t               out_data_q;

	logic                           out_free, done_s1, load_s1, crossed;
	logic [pip_pkg::TALLY_BITS-1:0] tally_next;

	// Only a closing edge has to wait for the result register.
	assign out_free  = !out_valid_q || out_ready;
	assign done_s1   = valid_s1 && (!last_s1 || out_free);
	assign load_s1   = !valid_s1 || done_s1;
	assign job_ready = load_s1;

	always_ff @(posedge clk) begin
		if (load_s1 && job_valid) begin
			kind_s1   <= job.kind;
			dx_neg_s1 <= job.dx_neg;
			last_s1   <= job.last_edge;
			lhs_s1    <= job.dpx * job.dy;
			rhs_s1    <= job.dpy * job.dx;
		end
	end

	// For a negative x span the height comparison flips its sense.
	always_comb begin
		case (kind_s1)
			pip_pkg::KIND_HIT:  crossed = 1'b1;
			pip_pkg::KIND_TEST: crossed = dx_neg_s1 ? (lhs_s1 >= rhs_s1) : (lhs_s1 <= rhs_s1);
			default:            crossed = 1'b0;
		endcase
		tally_next = (crossed && tally_q != pip_pkg::TALLY_MAX) ? tally_q + 1'b1 : tally_q;
	end

	always_ff @(posedge clk) begin
		if (done_s1 && last_s1) begin
			out_data_q.inside_res     <= parity_q ^ crossed;
			out_data_q.crossing_total <= tally_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			tally_q     <= '0;
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= job_valid;
			end
			if (done_s1) begin
				if (last_s1) begin
					tally_q  <= '0;
					parity_q <= 1'b0;
				end else begin
					tally_q  <= tally_next;
					parity_q <= parity_q ^ crossed;
				end
			end
			if (done_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 && last_s1 |=> tally_q == '0 && !parity_q)
		else $error("tally not cleared after closing edge");

	a_tally_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done_s1 |=> $stable(tally_q) && $stable(parity_q))
		else $error("tally changed with no edge retired");

	a_parity_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.crossing_total != pip_pkg::TALLY_MAX
		|-> out_data.inside_res == out_data.crossing_total[0])
		else $error("inside flag disagrees with unsaturated count");

endmodule

// ===== rtl/point_in_polygon_crossing_unit.sv =====
// Top level of the point-in-polygon crossing unit: front end, edge queue
// and back end. Depends on pip_pkg, pip_front, pip_fifo and pip_back.
//
//   Channel  Handshake             Payload             Direction
//   in       in_valid / in_ready   pip_pkg::edge_in_t  one polygon edge
//   out      out_valid / out_ready pip_pkg::result_t   one result per polygon
//
// Sustains one edge per clock while in_ready is high. A closing edge passes
// through the queue and then the product register before the result register
// loads and raises out_valid.
// Reset clears the queue pointers, the product stage valid, the tally and the
// result valid; nothing needs a clearing pass.
// A stalled result holds back only the next closing edge and the edges behind
// it; earlier edges keep retiring, and in_ready drops only when the QUEUE_DEPTH entry queue is full.
module point_in_polygon_crossing_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pip_pkg::edge_in_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pip_pkg::result_t  out_data
);

	pip_pkg::job_t front_job, queue_job;
	logic          queue_valid, queue_ready;

	pip_front u_front (
		.in_data (in_data),
		.job     (front_job)
	);

	pip_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (front_job),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_data   (queue_job)
	);

	pip_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (queue_valid),
		.job_ready (queue_ready),
		.job       (queue_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
